// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg - shared types and constants for the elevator scan scheduler
// Command encoding passed from the front classifier to the back executor.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Floor numbers are 5 bits on every port and inside the core.
    localparam int FLOOR_W = 5;

    // Entries in the front-to-back command queue.
    localparam int QUEUE_DEPTH = 2;

    // Input mode field codes.
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // Classified command kinds.
    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_TICK    = 2'd1,
        OP_REJECT  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FLOOR_W-1:0] floor;
    } t_cmd;

endpackage

// ===== src/esc_front.sv =====
// ----------------------------------------------------------------------------
// esc_front - input classifier
// Splits incoming beats into ticks, in-range requests and rejected requests.
// ----------------------------------------------------------------------------
module esc_front #(
    parameter int FLOORS = 16
) (
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [esc_pkg::FLOOR_W-1:0] i_request_floor,
    output logic                        o_push,
    output esc_pkg::t_cmd               o_cmd,
    input  logic                        i_queue_full
);

    localparam logic [esc_pkg::FLOOR_W-1:0] FLOOR_TOP = esc_pkg::FLOOR_W'(FLOORS);

    logic out_of_range;

    assign out_of_range = (i_request_floor == '0) || (i_request_floor > FLOOR_TOP);

    always_comb begin
        o_cmd.floor = i_request_floor;
        if (i_mode == esc_pkg::MODE_TICK) begin
            o_cmd.op = esc_pkg::OP_TICK;
        end else if (out_of_range) begin
            o_cmd.op = esc_pkg::OP_REJECT;
        end else begin
            o_cmd.op = esc_pkg::OP_REQUEST;
        end
    end

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

endmodule

// ===== src/esc_queue.sv =====
// ----------------------------------------------------------------------------
// esc_queue - command queue between front and back
// Small register FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
module esc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output esc_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(esc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(esc_pkg::QUEUE_DEPTH + 1);

    esc_pkg::t_cmd r_mem [esc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(esc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(esc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(esc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    // pop only from a non-empty queue, push only into a non-full one
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
`endif

endmodule

// ===== src/esc_back.sv =====
// ----------------------------------------------------------------------------
// esc_back - SCAN executor
// Holds car state and pending bitmaps; runs one command per beat.
// ----------------------------------------------------------------------------
module esc_back #(
    parameter int FLOORS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  esc_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [esc_pkg::FLOOR_W-1:0] o_car_floor,
    output logic                        o_going_up,
    output logic                        o_car_idle,
    output logic                        o_door_open,
    output logic                        o_rejected
);

    localparam int FW = esc_pkg::FLOOR_W;
    localparam logic [FW-1:0]     FLOOR_TOP = FW'(FLOORS);
    localparam logic [FW-1:0]     FLOOR_BOT = FW'(1);
    localparam logic [FLOORS-1:0] BIT_ONE   = FLOORS'(1);

    logic [FW-1:0]     r_floor, n_floor;
    logic              r_dir_up, n_dir_up;
    logic              r_idle, n_idle;
    logic [FLOORS-1:0] r_up, n_up;
    logic [FLOORS-1:0] r_down, n_down;
    logic              r_door, n_door;
    logic              r_rej, n_rej;
    logic              r_out_valid;

    logic              t_dir;
    logic [FW-1:0]     t_floor;
    logic [FLOORS-1:0] t_mask;
    logic              t_hit;
    logic [FLOORS-1:0] req_mask;

    // car state only changes on a pop, so it doubles as the output payload
    assign o_pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_car_floor = r_floor;
    assign o_going_up  = r_dir_up;
    assign o_car_idle  = r_idle;
    assign o_door_open = r_door;
    assign o_rejected  = r_rej;

    // tick datapath: reverse at an end, step one floor, look up the stop
    always_comb begin
        t_dir   = r_dir_up ? (r_floor < FLOOR_TOP) : (r_floor <= FLOOR_BOT);
        t_floor = t_dir ? r_floor + 1'b1 : r_floor - 1'b1;
        t_mask  = BIT_ONE << (t_floor - 1'b1);
        t_hit   = t_dir ? |(r_up & t_mask) : |(r_down & t_mask);
    end

    assign req_mask = BIT_ONE << (i_cmd.floor - 1'b1);

    always_comb begin
        n_floor  = r_floor;
        n_dir_up = r_dir_up;
        n_idle   = r_idle;
        n_up     = r_up;
        n_down   = r_down;
        n_door   = 1'b0;
        n_rej    = 1'b0;
        unique case (i_cmd.op)
            esc_pkg::OP_REJECT: begin
                n_rej = 1'b1;
            end
            esc_pkg::OP_REQUEST: begin
                if (i_cmd.floor == r_floor) begin
                    n_door = 1'b1;
                end else if (i_cmd.floor > r_floor) begin
                    n_up = r_up | req_mask;
                    if (r_idle) begin
                        n_idle   = 1'b0;
                        n_dir_up = 1'b1;
                    end
                end else begin
                    n_down = r_down | req_mask;
                    if (r_idle) begin
                        n_idle   = 1'b0;
                        n_dir_up = 1'b0;
                    end
                end
            end
            esc_pkg::OP_TICK: begin
                if (!r_idle) begin
                    n_floor  = t_floor;
                    n_dir_up = t_dir;
                    if (t_hit) begin
                        n_door = 1'b1;
                        if (t_dir) begin
                            n_up = r_up & ~t_mask;
                        end else begin
                            n_down = r_down & ~t_mask;
                        end
                        n_idle = (n_up == '0) && (n_down == '0);
                    end
                    if (t_dir && (t_floor == FLOOR_TOP)) begin
                        n_dir_up = 1'b0;
                    end else if (!t_dir && (t_floor == FLOOR_BOT)) begin
                        n_dir_up = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= FLOOR_BOT;
            r_dir_up    <= 1'b1;
            r_idle      <= 1'b1;
            r_up        <= '0;
            r_down      <= '0;
            r_door      <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_floor  <= n_floor;
                r_dir_up <= n_dir_up;
                r_idle   <= n_idle;
                r_up     <= n_up;
                r_down   <= n_down;
                r_door   <= n_door;
                r_rej    <= n_rej;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_floor >= FLOOR_BOT) && (r_floor <= FLOOR_TOP))
        else $error("car floor out of range");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle |-> ((r_up == '0) && (r_down == '0)))
        else $error("idle car with pending requests");
    a_door_xor_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_door && r_rej))
        else $error("door open on rejected request");
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == esc_pkg::OP_REJECT)) |=>
            ($stable(r_floor) && $stable(r_up) && $stable(r_down) && $stable(r_idle)))
        else $error("rejected request changed car state");
`endif

endmodule

// ===== src/elevator_scan_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// elevator_scan_scheduler_top - single-car SCAN elevator scheduler
// Takes floor requests and movement ticks, returns the car state per beat.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready   | i_mode, i_request_floor
//  out      | o_out_valid / i_out_ready | o_car_floor, o_going_up, o_car_idle,
//           |                           | o_door_open, o_rejected
//
// One beat in, one beat out. Sustained rate is one beat per cycle while the
// output is not stalled; an accepted beat is written into the queue, and the
// back then writes the car-state/output register when it pops it.
// The front only classifies (tick, request, out-of-range) and writes a
// two-entry queue; while the output is not stalled, the back applies one
// command per cycle to car state and up/down pending bitmaps, combinationally.
// Synchronous active-low reset: car at floor 1, heading up, idle, no pending
// floors, queue empty, no result waiting.
// A stalled output holds the back; the queue keeps taking beats until full.
// ----------------------------------------------------------------------------
module elevator_scan_scheduler_top #(
    parameter int FLOORS = 16     // 2..31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [esc_pkg::FLOOR_W-1:0] i_request_floor,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [esc_pkg::FLOOR_W-1:0] o_car_floor,
    output logic                        o_going_up,
    output logic                        o_car_idle,
    output logic                        o_door_open,
    output logic                        o_rejected
);

    // front -> queue
    logic          push;
    esc_pkg::t_cmd push_cmd;
    logic          queue_full;

    // queue -> back
    logic          pop;
    logic          cmd_valid;
    esc_pkg::t_cmd cmd;

    esc_front #(
        .FLOORS(FLOORS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_request_floor(i_request_floor),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_queue_full   (queue_full)
    );

    esc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_valid(cmd_valid),
        .o_cmd  (cmd)
    );

    // back: car state machine plus output register
    esc_back #(
        .FLOORS(FLOORS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_car_floor(o_car_floor),
        .o_going_up (o_going_up),
        .o_car_idle (o_car_idle),
        .o_door_open(o_door_open),
        .o_rejected (o_rejected)
    );

endmodule
